// ----- src/imm_pkg.sv -----
// ----------------------------------------------------------------------------
// imm_pkg
// Shared types and constants of the integer matrix multiply unit: item
// structs, request codes, controller states and the controller/datapath link.
// ----------------------------------------------------------------------------
package imm_pkg;

    localparam int DIM_DEFAULT = 64;
    localparam int INNER_W     = 7;
    localparam logic [INNER_W-1:0] INNER_RESET = 7'd64;

    localparam logic [1:0] FUNC_WR_LEFT  = 2'd0;
    localparam logic [1:0] FUNC_WR_RIGHT = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE  = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] product_element;
        logic [5:0]         out_row;
        logic [5:0]         out_col;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic wr_left;
        logic wr_right;
        logic start;
        logic issue;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic empty_job;
        logic last_issue;
        logic pipe_empty;
        logic out_free;
    } t_dp_status;

endpackage

// ----- src/imm_ctrl.sv -----
// ----------------------------------------------------------------------------
// imm_ctrl
// Sequencer: decodes input beats, steps the datapath through the inner
// dimension of a compute item and hands the finished sum to the output.
// ----------------------------------------------------------------------------
module imm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_func,
    input  imm_pkg::t_dp_status i_status,
    output logic                o_in_stall,
    output imm_pkg::t_dp_cmd    o_cmd
);
    import imm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_func == FUNC_COMPUTE) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (i_status.empty_job || i_status.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_status.pipe_empty && i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.wr_left  = (i_func == FUNC_WR_LEFT);
                    o_cmd.wr_right = (i_func == FUNC_WR_RIGHT);
                    o_cmd.start    = (i_func == FUNC_COMPUTE);
                end
            end
            S_ISSUE: begin
                o_cmd.issue = !i_status.empty_job;
            end
            S_DRAIN: begin
                // hold the sum until the output register can take it
                o_cmd.load_out = i_status.pipe_empty && i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ----- src/imm_datapath.sv -----
// ----------------------------------------------------------------------------
// imm_datapath
// Matrix stores, read / multiply / accumulate pipeline, inner length
// register and the output register.
// ----------------------------------------------------------------------------
module imm_datapath #(
    parameter int DIM = imm_pkg::DIM_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  imm_pkg::t_in_item            i_in_item,
    input  imm_pkg::t_dp_cmd             i_cmd,
    input  logic                         i_cfg_we,
    input  logic [imm_pkg::INNER_W-1:0]  i_cfg_data,
    input  logic                         i_out_stall,
    output imm_pkg::t_dp_status          o_status,
    output logic                         o_out_valid,
    output imm_pkg::t_out_item           o_out_item
);
    import imm_pkg::*;

    localparam int IDX_W  = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int CNT_W  = $clog2(DIM + 1);
    localparam int DEPTH  = DIM * DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0] left_mem  [DEPTH];
    logic [31:0] right_mem [DEPTH];

    logic [INNER_W-1:0] r_inner;
    logic [IDX_W-1:0]   r_row;
    logic [IDX_W-1:0]   r_col;
    logic [5:0]         r_row_tag;
    logic [5:0]         r_col_tag;
    logic [CNT_W-1:0]   r_n;
    logic               r_empty;
    logic [IDX_W-1:0]   r_k;
    logic               r_v1;
    logic               r_v2;
    logic [31:0]        r_rd_a;
    logic [31:0]        r_rd_b;
    logic [31:0]        r_prod;
    logic [31:0]        r_acc;
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic               in_range;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr_a;
    logic [ADDR_W-1:0]  rd_addr_b;
    logic [CNT_W-1:0]   n_len;

    assign in_range = (32'(i_in_item.row) < 32'(DIM)) && (32'(i_in_item.col) < 32'(DIM));
    assign wr_addr  = ADDR_W'(IDX_W'(i_in_item.row)) * ADDR_W'(DIM)
                    + ADDR_W'(IDX_W'(i_in_item.col));
    assign rd_addr_a = ADDR_W'(r_row) * ADDR_W'(DIM) + ADDR_W'(r_k);
    assign rd_addr_b = ADDR_W'(r_k) * ADDR_W'(DIM) + ADDR_W'(r_col);

    // saturate the configured length at the matrix size
    assign n_len = (32'(r_inner) > 32'(DIM)) ? CNT_W'(DIM) : CNT_W'(r_inner);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_left && in_range) begin
            left_mem[wr_addr] <= i_in_item.value;
        end
        if (i_cmd.issue) begin
            r_rd_a <= left_mem[rd_addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_right && in_range) begin
            right_mem[wr_addr] <= i_in_item.value;
        end
        if (i_cmd.issue) begin
            r_rd_b <= right_mem[rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner     <= INNER_RESET;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_inner <= i_cfg_data;
            end
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_row     <= IDX_W'(i_in_item.row);
            r_col     <= IDX_W'(i_in_item.col);
            r_row_tag <= i_in_item.row;
            r_col_tag <= i_in_item.col;
            r_n       <= n_len;
            r_empty   <= !in_range || (n_len == '0);
            r_k       <= '0;
        end else if (i_cmd.issue) begin
            r_k <= r_k + IDX_W'(1);
        end
        r_prod <= r_rd_a * r_rd_b;
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + r_prod;
        end
        if (i_cmd.load_out) begin
            r_out_item.product_element <= r_acc;
            r_out_item.out_row         <= r_row_tag;
            r_out_item.out_col         <= r_col_tag;
        end
    end

    assign o_status.empty_job  = r_empty;
    assign o_status.last_issue = (CNT_W'(r_k) + CNT_W'(1)) == r_n;
    assign o_status.pipe_empty = !r_v1 && !r_v2;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid         = r_out_valid;
    assign o_out_item          = r_out_item;

endmodule

// ----- src/integer_matrix_multiply_unit.sv -----
// ----------------------------------------------------------------------------
// integer_matrix_multiply_unit
// Stores two DIM x DIM signed 32-bit matrices and returns single elements of
// their product, wrapped to 32 bits.
// ----------------------------------------------------------------------------
// A write beat (left or right element) is taken whenever the unit is idle.
// A compute beat holds further beats until its sum is done: with n the inner
// length clipped to DIM, it makes one read of each store and one
// multiply-accumulate per term, then drains the read, multiply and accumulate
// stages. An empty sum (n of zero or an index of DIM or more) reads nothing.
// The result waits in an output register, so input beats keep flowing while
// it is stalled; a later compute beat only holds once its own result is ready.
// Stores come up undefined; read only elements that were written.
module integer_matrix_multiply_unit #(
    parameter int DIM = imm_pkg::DIM_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  imm_pkg::t_in_item            i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output imm_pkg::t_out_item           o_out_item,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [imm_pkg::INNER_W-1:0]  i_cfg_data
);
    import imm_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    imm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in_item.func),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    imm_datapath #(
        .DIM (DIM)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.wr_left, cmd.wr_right, cmd.start, cmd.issue, cmd.load_out}))
        else $error("more than one datapath command at once");

    a_no_issue_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.issue |-> !status.empty_job)
        else $error("read issued for an empty sum");

    a_load_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (status.pipe_empty && status.out_free))
        else $error("result loaded before the pipeline drained");

    a_compute_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_item.func == FUNC_COMPUTE) |=> o_in_stall)
        else $error("input not held after a compute beat");

endmodule
